>>> sv/line_keyword_command_detector_unit_defines.svh
// Assertion macros shared by the line keyword command detector RTL.
`ifndef LINE_KEYWORD_COMMAND_DETECTOR_UNIT_DEFINES_SVH
`define LINE_KEYWORD_COMMAND_DETECTOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check an implication or plain property on every clock edge out of reset.
`define LCD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lcd assertion failed");
// Check that a condition never holds out of reset.
`define LCD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lcd forbidden condition seen");
`else
`define LCD_ASSERT(lbl, clk, rst_n, prop)
`define LCD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> sv/lcd_pkg.sv
// Package with constants and types of the line keyword command detector.
`default_nettype none
package lcd_pkg;

    localparam int LINE_BYTES_DEF = 64;

    localparam logic CMD_UNLOCK = 1'b0;
    localparam logic CMD_LOCK   = 1'b1;

    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam int UNLOCK_LEN = 6;
    localparam int LOCK_LEN   = 4;
    localparam int UNLOCK_PW  = $clog2(UNLOCK_LEN);
    localparam int LOCK_PW    = $clog2(LOCK_LEN);

    // First letter in the top byte, as a string literal packs it.
    localparam logic [8*UNLOCK_LEN-1:0] WORD_UNLOCK = "UNLOCK";
    localparam logic [8*LOCK_LEN-1:0]   WORD_LOCK   = "LOCK";

    // Per-byte decode of the registered input byte.
    typedef struct packed {
        logic line_end;
        logic is_cr;
        logic is_nul;
    } lcd_byte_kind_t;

endpackage
`default_nettype wire

>>> sv/line_keyword_command_detector_unit.sv
// Top level of the line keyword command detector: byte stream in, command stream out.
//
//  channel | dir | tdata bits (low bit up)          | accepted when
//  --------+-----+----------------------------------+-----------------------------
//  s_axis  | in  | [7:0] rx_char                    | s_axis_tvalid & s_axis_tready
//  m_axis  | out | [0] command, [7:1] zero          | m_axis_tvalid & m_axis_tready
//
//  One byte per cycle sustained while the result slot is free or drained; each byte
//  passes the input register, then the result register, with the single update pass over
//  the line counter and the two keyword trackers.
//  A byte waiting in the input register is held only while a command sits unread
//  in the result register; new bytes are taken in the same cycle the slot frees.
//  Reset (rst_n low, asynchronous) empties both registers and clears the line.
//  Only a line end with a keyword seen produces a beat on m_axis.
`default_nettype none
`include "line_keyword_command_detector_unit_defines.svh"
module line_keyword_command_detector_unit
    import lcd_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_char
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic      [7:0] m_axis_tdata    // [0] command, [7:1] zero
);

    localparam int LEN_W = $clog2(LINE_BYTES);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_BYTES - 1);

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;

    // Line state.
    logic [LEN_W-1:0]     line_len_reg, line_len_next;
    logic [UNLOCK_PW-1:0] unlock_prog_reg, unlock_prog_next;
    logic [LOCK_PW-1:0]   lock_prog_reg, lock_prog_next;
    logic                 unlock_seen_reg, unlock_seen_next;
    logic                 lock_seen_reg, lock_seen_next;
    logic                 text_ended_reg, text_ended_next;

    // Result register.
    logic out_valid_reg, out_valid_next;
    logic out_cmd_reg, out_cmd_next;

    logic                 advance;
    logic                 emit;
    lcd_byte_kind_t       kind;
    logic [UNLOCK_PW-1:0] unlock_prog_trk;
    logic [LOCK_PW-1:0]   lock_prog_trk;
    logic                 unlock_hit;
    logic                 lock_hit;

    // Advance the held byte whenever the result slot is free or being drained.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign kind.line_end = (in_char_reg == CHAR_LF) || (line_len_reg >= LEN_FULL);
    assign kind.is_cr    = (in_char_reg == CHAR_CR);
    assign kind.is_nul   = (in_char_reg == CHAR_NUL);

    lcd_match #(
        .WORD_LEN (UNLOCK_LEN),
        .WORD     (WORD_UNLOCK)
    ) u_unlock (
        .progress      (unlock_prog_reg),
        .ch            (in_char_reg),
        .progress_next (unlock_prog_trk),
        .hit           (unlock_hit)
    );

    lcd_match #(
        .WORD_LEN (LOCK_LEN),
        .WORD     (WORD_LOCK)
    ) u_lock (
        .progress      (lock_prog_reg),
        .ch            (in_char_reg),
        .progress_next (lock_prog_trk),
        .hit           (lock_hit)
    );

    assign in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;

    // Line state update for the byte in the input register.
    always_comb
    begin
        line_len_next    = line_len_reg;
        unlock_prog_next = unlock_prog_reg;
        lock_prog_next   = lock_prog_reg;
        unlock_seen_next = unlock_seen_reg;
        lock_seen_next   = lock_seen_reg;
        text_ended_next  = text_ended_reg;
        if (advance)
        begin
            if (kind.line_end)
            begin
                // Drop the byte and start a fresh line.
                line_len_next    = '0;
                unlock_prog_next = '0;
                lock_prog_next   = '0;
                unlock_seen_next = 1'b0;
                lock_seen_next   = 1'b0;
                text_ended_next  = 1'b0;
            end
            else if (!kind.is_cr)
            begin
                line_len_next = line_len_reg + LEN_W'(1);
                if (!text_ended_reg)
                begin
                    if (kind.is_nul)
                    begin
                        // A zero byte closes the searchable text.
                        text_ended_next = 1'b1;
                    end
                    else
                    begin
                        unlock_prog_next = unlock_prog_trk;
                        lock_prog_next   = lock_prog_trk;
                        unlock_seen_next = unlock_seen_reg || unlock_hit;
                        lock_seen_next   = lock_seen_reg || lock_hit;
                    end
                end
            end
        end
    end

    // Result register: unlock wins over lock.
    assign emit = kind.line_end && (unlock_seen_reg || lock_seen_reg);

    always_comb
    begin
        out_cmd_next = out_cmd_reg;
        if (advance)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                out_cmd_next = unlock_seen_reg ? CMD_UNLOCK : CMD_LOCK;
            end
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_axis_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            line_len_reg    <= '0;
            unlock_prog_reg <= '0;
            lock_prog_reg   <= '0;
            unlock_seen_reg <= 1'b0;
            lock_seen_reg   <= 1'b0;
            text_ended_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            line_len_reg    <= line_len_next;
            unlock_prog_reg <= unlock_prog_next;
            lock_prog_reg   <= lock_prog_next;
            unlock_seen_reg <= unlock_seen_next;
            lock_seen_reg   <= lock_seen_next;
            text_ended_reg  <= text_ended_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
        end
        out_cmd_reg <= out_cmd_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_cmd_reg};

    // The line counter never passes the full mark.
    `LCD_ASSERT_NEVER(a_len_range, clk, rst_n, line_len_reg > LEN_FULL)
    // A line end leaves the line state cleared.
    `LCD_ASSERT(a_clear_on_end, clk, rst_n,
        advance && kind.line_end |=> line_len_reg == '0 && !unlock_seen_reg
        && !lock_seen_reg && !text_ended_reg)
    // After a zero byte the keyword flags stay put until the line ends.
    `LCD_ASSERT(a_text_frozen, clk, rst_n,
        text_ended_reg && advance && !kind.line_end |=> $stable(unlock_seen_reg)
        && $stable(lock_seen_reg))
    // Only a line end can load a new result.
    `LCD_ASSERT(a_result_on_end, clk, rst_n,
        advance && !kind.line_end |=> !out_valid_reg)
    // A held byte never advances over an unread result.
    `LCD_ASSERT_NEVER(a_no_overrun, clk, rst_n,
        advance && out_valid_reg && !m_axis_tready)

endmodule
`default_nettype wire

>>> sv/lcd_match.sv
// Substring tracker for one keyword whose letters are all distinct.
`default_nettype none
module lcd_match
    import lcd_pkg::*;
#(
    parameter int                    WORD_LEN = UNLOCK_LEN,
    parameter logic [8*WORD_LEN-1:0] WORD     = WORD_UNLOCK
)
(
    input  wire logic [$clog2(WORD_LEN)-1:0] progress,
    input  wire logic [7:0]                  ch,
    output logic      [$clog2(WORD_LEN)-1:0] progress_next,
    output logic                             hit
);

    localparam int PW = $clog2(WORD_LEN);

    logic [7:0]  expect_ch;
    logic [7:0]  first_ch;
    logic [PW:0] inc;

    assign first_ch = WORD[8*WORD_LEN-1 -: 8];

    // Pick the letter the tracker waits for.
    always_comb
    begin
        expect_ch = first_ch;
        for (int i = 0; i < WORD_LEN; i++)
        begin
            if (progress == PW'(i))
            begin
                expect_ch = WORD[8*(WORD_LEN-1-i) +: 8];
            end
        end
    end

    assign inc = {1'b0, progress} + {{PW{1'b0}}, 1'b1};

    always_comb
    begin
        hit           = 1'b0;
        progress_next = '0;
        if (ch == expect_ch)
        begin
            if (inc == (PW+1)'(WORD_LEN))
            begin
                hit = 1'b1;
            end
            else
            begin
                progress_next = inc[PW-1:0];
            end
        end
        else if (ch == first_ch)
        begin
            // Restart on the first letter.
            progress_next = PW'(1);
        end
    end

endmodule
`default_nettype wire

>>> tb/sv/tb_line_keyword_command_detector_unit.sv
// Self-checking testbench for the line keyword command detector: byte stream in, commands out.
module tb_line_keyword_command_detector_unit;
    import lcd_pkg::*;

    localparam int LINE_MAX     = LINE_BYTES_DEF;
    localparam int ITEMS        = 1800;
    localparam int LONG_HOLD    = 400;   // receiver hold-off that backs the block up
    localparam int IDLE_LIMIT   = 4000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 10;    // two-stage pipe plus margin
    localparam int PRINT_CAP    = 50;

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    // Bytes still to be sent, oldest first; the driver owns the head.
    logic [7:0] rx_bytes[$];
    // Commands the line scanner says must come out, oldest first.
    logic       pending_cmds[$];

    // Line scanner state, mirrors what the block tracks per line.
    int   line_len    = 0;
    int   unlock_pos  = 0;
    int   lock_pos    = 0;
    logic unlock_hit  = 1'b0;
    logic lock_hit    = 1'b0;
    logic text_done   = 1'b0;

    int   mismatches  = 0;
    int   idle_cycles = 0;
    int   send_gap    = 0;
    int   send_calm   = 0;
    logic send_offer;
    int   recv_gap    = 0;
    int   recv_calm   = 0;
    int   recv_hold   = 0;
    int   beats_out   = 0;

    line_keyword_command_detector_unit #(
        .LINE_BYTES(LINE_MAX)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // [7:0] rx_char
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)    // [0] command, [7:1] zero
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch @%0t: %s", $time, what);
    endtask

    // Idle length between beats: mostly none or short, a few long, and now and
    // then a calm stretch where every gap is zero.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advance one substring tracker. The letters of both words are distinct, so
    // a mismatch can only restart the match at the word's first letter. The word
    // sits right-aligned with its first letter in the highest used byte.
    function automatic int step_tracker(input int pos, input int len,
                                        input logic [8*UNLOCK_LEN-1:0] word,
                                        input logic [7:0] ch, inout logic hit);
        if (pos >= len)
            pos = 0;
        if (ch == word[8*(len-1-pos) +: 8])
        begin
            pos++;
            if (pos == len)
            begin
                hit = 1'b1;
                pos = 0;
            end
            return pos;
        end
        return (ch == word[8*(len-1) +: 8]) ? 1 : 0;
    endfunction

    // Feed one accepted byte through the line scanner; queue a command when a
    // line closes with a keyword in it (UNLOCK wins over LOCK).
    function automatic void scan_rx_char(input logic [7:0] ch);
        if (ch == CHAR_LF || line_len >= LINE_MAX - 1)
        begin
            // A full line swallows the byte that closes it, whatever it is.
            if (unlock_hit)
                pending_cmds.push_back(CMD_UNLOCK);
            else if (lock_hit)
                pending_cmds.push_back(CMD_LOCK);
            line_len   = 0;
            unlock_pos = 0;
            lock_pos   = 0;
            unlock_hit = 1'b0;
            lock_hit   = 1'b0;
            text_done  = 1'b0;
        end
        else if (ch != CHAR_CR)
        begin
            line_len++;
            // A zero byte counts toward the length but ends the searchable text.
            if (!text_done)
            begin
                if (ch == CHAR_NUL)
                    text_done = 1'b1;
                else
                begin
                    unlock_pos = step_tracker(unlock_pos, UNLOCK_LEN, WORD_UNLOCK, ch,
                                              unlock_hit);
                    lock_pos = step_tracker(lock_pos, LOCK_LEN,
                                            (8*UNLOCK_LEN)'(WORD_LOCK), ch, lock_hit);
                end
            end
        end
    endfunction

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            rx_bytes.push_back(s[i]);
    endtask

    // Driver: offer the head of the byte queue, run the scanner on each
    // accepted beat, then idle for a random gap before the next offer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            send_gap = 0;
        end
        else
        begin
            send_offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                scan_rx_char(s_axis_tdata);
                rx_bytes.delete(0);
                send_gap   = pick_gap(send_calm);
                send_offer = 1'b0;
            end
            if (!send_offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (rx_bytes.size() != 0)
                    send_offer = 1'b1;
            end
            // Hold valid high across back-to-back beats: one assignment per edge.
            s_axis_tvalid <= send_offer;
            if (send_offer)
                s_axis_tdata <= rx_bytes[0];
        end
    end

    // Monitor: compare each command beat with the oldest expectation and
    // stall the output at random, with a long hold-off every so often.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap  = 0;
            recv_hold = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_cmds.size() == 0)
                    report_mismatch($sformatf("command %0d with none expected",
                                              m_axis_tdata[0]));
                else
                begin
                    if (m_axis_tdata[0] !== pending_cmds[0])
                        report_mismatch($sformatf("command got %0d expected %0d",
                                                  m_axis_tdata[0], pending_cmds[0]));
                    pending_cmds.delete(0);
                end
                if (m_axis_tdata[7:1] !== 7'd0)
                    report_mismatch($sformatf("padding bits got %h", m_axis_tdata[7:1]));
                beats_out++;
                // Starve the output now and then so the input side backs up.
                if (beats_out % 37 == 5)
                    recv_hold = LONG_HOLD;
                else
                    recv_gap = pick_gap(recv_calm);
            end
            else if (!m_axis_tvalid && recv_gap == 0 && $urandom_range(0, 15) == 0)
                recv_gap = pick_gap(recv_calm);

            if (recv_hold > 0)
            begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: give up when work is outstanding but nothing moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else if (rx_bytes.size() != 0 || pending_cmds.size() != 0)
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int    kind;
        int    target;
        int    start;
        int    pick;
        string kw_unlock;
        string kw_lock;

        kw_unlock = "UNLOCK";
        kw_lock   = "LOCK";

        // Directed lines: both words (UNLOCK wins), a carriage return inside a
        // word plus the top byte value, an empty line, and a zero byte that hides
        // the word after it.
        put_text("LOCKUNLOCK");
        rx_bytes.push_back(CHAR_LF);
        rx_bytes.push_back(8'hFF);
        put_text("LO");
        rx_bytes.push_back(CHAR_CR);
        put_text("CK");
        rx_bytes.push_back(CHAR_LF);
        rx_bytes.push_back(CHAR_LF);
        rx_bytes.push_back(CHAR_NUL);
        put_text("LOCK");
        rx_bytes.push_back(CHAR_LF);

        // Random lines: mostly keyword-rich text, some overlong lines that hit
        // the length limit, and some raw noise.
        while (rx_bytes.size() < ITEMS)
        begin
            kind  = $urandom_range(0, 9);
            start = rx_bytes.size();
            if (kind < 8)
            begin
                target = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 80)
                                                     : $urandom_range(0, 24);
                while (rx_bytes.size() - start < target)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 3)
                        put_text(kw_unlock);
                    else if (pick < 6)
                        put_text(kw_lock);
                    else if (pick < 8)
                        put_text(kw_unlock.substr(0, $urandom_range(0, 4)));
                    else if (pick == 8)
                        rx_bytes.push_back(CHAR_CR);
                    else if (pick == 9 && $urandom_range(0, 3) == 0)
                        rx_bytes.push_back(CHAR_NUL);
                    else if (pick < 16)
                        rx_bytes.push_back(kw_unlock[$urandom_range(0, 5)]);
                    else
                        rx_bytes.push_back(8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 3) == 0)
                    rx_bytes.push_back(CHAR_CR);
                rx_bytes.push_back(CHAR_LF);
            end
            else
            begin
                target = $urandom_range(1, 30);
                repeat (target)
                    rx_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_bytes.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_cmds.size() != 0)
            report_mismatch($sformatf("%0d commands never arrived", pending_cmds.size()));

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> line_keyword_command_detector_unit.f
+incdir+sv
sv/lcd_pkg.sv
sv/lcd_match.sv
sv/line_keyword_command_detector_unit.sv
tb/sv/tb_line_keyword_command_detector_unit.sv
